[hw/rtl/column_bound_search_defines.svh]
`ifndef COLUMN_BOUND_SEARCH_DEFINES_SVH
`define COLUMN_BOUND_SEARCH_DEFINES_SVH

// Property that must hold at every rising clock edge outside reset.
`define CBS_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true at a rising clock edge outside reset.
`define CBS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[hw/rtl/cbs_pkg.sv]
`timescale 1ns / 1ps

package cbs_pkg;

   localparam int POS_W = 11;
   localparam int ROW_W = 10;
   localparam int COL_W = 3;
   localparam int WORD_W = 32;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_LOWER  = 2'd1,
      OP_UPPER  = 2'd2,
      OP_MEMBER = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    opcode;
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          column;
      logic signed [WORD_W-1:0]  value;
      logic [POS_W-1:0]          range_begin;
      logic [POS_W-1:0]          range_end;
      logic signed [WORD_W-1:0]  target;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             found;
   } rsp_type;

   // Outcome of one probe of the search window.
   typedef struct packed {
      logic [POS_W-1:0] mid;
      logic [POS_W-1:0] lo_next;
      logic [POS_W-1:0] count_next;
      logic [POS_W-1:0] mid_next;
      logic             key_lt_entry;
   } step_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ISSUE  = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_CHECK  = 4'b1000
   } state_type;

endpackage

[hw/rtl/cbs_ram.sv]
`timescale 1ns / 1ps

module cbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/cbs_step.sv]
`timescale 1ns / 1ps

module cbs_step
   import cbs_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic [POS_W-1:0]             lo,
   input  logic [POS_W-1:0]             count,
   input  logic signed [DATA_WIDTH-1:0] entry,
   input  logic signed [DATA_WIDTH-1:0] key,
   input  logic                         upper,
   output step_type                     step
);

   logic [POS_W-1:0] half;
   logic [POS_W-1:0] mid;
   logic [POS_W-1:0] lo_right;
   logic [POS_W-1:0] count_right;
   logic [POS_W-1:0] mid_right;
   logic [POS_W-1:0] mid_left;
   logic             entry_lt_key;
   logic             key_lt_entry;
   logic             go_right;

   // Both candidate windows are formed from registers, so the compare only
   // drives the final selection.
   always_comb begin
      half         = count >> 1;
      mid          = lo + half;
      lo_right     = mid + POS_W'(1);
      count_right  = count - half - POS_W'(1);
      mid_right    = lo_right + (count_right >> 1);
      mid_left     = lo + (half >> 1);
      entry_lt_key = entry < key;
      key_lt_entry = key < entry;
      go_right     = upper ? !key_lt_entry : entry_lt_key;

      step.mid          = mid;
      step.key_lt_entry = key_lt_entry;
      if (go_right) begin
         step.lo_next    = lo_right;
         step.count_next = count_right;
         step.mid_next   = mid_right;
      end else begin
         step.lo_next    = lo;
         step.count_next = half;
         step.mid_next   = mid_left;
      end
   end

endmodule

[hw/rtl/column_bound_search.sv]
`timescale 1ns / 1ps
// Write request: stored at the accepting edge if row and column fit, busy stays low, no response.
// Query: with an empty range the response strobe shows in the cycle after accept; otherwise
// ISSUE starts the table read, then SEARCH does one probe per read (at most 11 probes for a
// 1024-row range) and membership adds a CHECK read unless the bound hits the range end.
// The receiver cannot stall; busy is high from accept until the response shows, except for an empty range.
// Synchronous reset clears the sequencer and the strobe; table contents are not cleared.
`include "column_bound_search_defines.svh"

module column_bound_search
   import cbs_pkg::*;
#(
   parameter int ROWS       = 1024,
   parameter int COLS       = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   function automatic logic signed [DATA_WIDTH-1:0] fit_word(input logic [WORD_W-1:0] v);
      logic [63:0] ext;
      ext = {{(64 - WORD_W){v[WORD_W-1]}}, v};
      return ext[DATA_WIDTH-1:0];
   endfunction

   state_type                    state_ff, state_in;
   logic [POS_W-1:0]             lo_ff, lo_in;
   logic [POS_W-1:0]             count_ff, count_in;
   logic [POS_W-1:0]             hi_ff, hi_in;
   logic signed [DATA_WIDTH-1:0] key_ff, key_in;
   logic [AW-1:0]                base_ff, base_in;
   logic                         col_ok_ff, col_ok_in;
   logic                         upper_ff, upper_in;
   logic                         member_ff, member_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   logic                         req_fire;
   logic                         row_ok;
   logic                         col_ok;
   logic [POS_W-1:0]             hi_sat;
   logic [31:0]                  col_offset;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic                         rd_en;
   logic [POS_W-1:0]             rd_row;
   logic [AW-1:0]                rd_addr;
   logic [DATA_WIDTH-1:0]        ram_q;
   logic signed [DATA_WIDTH-1:0] entry;
   step_type                     step;

   assign req_fire   = start && !busy;
   assign row_ok     = 32'(req_data.row) < 32'(ROWS);
   assign col_ok     = 32'(req_data.column) < 32'(COLS);
   assign hi_sat     = (32'(req_data.range_end) > 32'(ROWS)) ? POS_W'(ROWS)
                                                              : req_data.range_end;
   assign col_offset = 32'(req_data.column) * 32'(ROWS);
   assign wr_addr    = AW'(col_offset + 32'(req_data.row));
   assign rd_addr    = AW'(32'(base_ff) + 32'(rd_row));

   // A column past the table reads as zero.
   assign entry = col_ok_ff ? $signed(ram_q) : '0;

   cbs_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (fit_word(req_data.value)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   cbs_step #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_step (
      .lo    (lo_ff),
      .count (count_ff),
      .entry (entry),
      .key   (key_ff),
      .upper (upper_ff),
      .step  (step)
   );

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      count_in     = count_ff;
      hi_in        = hi_ff;
      key_in       = key_ff;
      base_in      = base_ff;
      col_ok_in    = col_ok_ff;
      upper_in     = upper_ff;
      member_in    = member_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_row       = step.mid;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.opcode == OP_WRITE) begin
                  wr_en = row_ok && col_ok;
               end else begin
                  lo_in     = req_data.range_begin;
                  count_in  = hi_sat - req_data.range_begin;
                  hi_in     = hi_sat;
                  key_in    = fit_word(req_data.target);
                  base_in   = col_ok ? AW'(col_offset) : '0;
                  col_ok_in = col_ok;
                  upper_in  = req_data.opcode == OP_UPPER;
                  member_in = req_data.opcode == OP_MEMBER;
                  if (req_data.range_begin >= hi_sat) begin
                     rsp_valid_in    = 1'b1;
                     rsp_in.position = req_data.range_begin;
                     rsp_in.found    = 1'b0;
                  end else begin
                     state_in = ST_ISSUE;
                  end
               end
            end
         end
         ST_ISSUE: begin
            rd_en    = 1'b1;
            rd_row   = step.mid;
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            rd_en    = 1'b1;
            lo_in    = step.lo_next;
            count_in = step.count_next;
            if (step.count_next != '0) begin
               rd_row = step.mid_next;
            end else begin
               // The window is closed; membership still needs the entry at the bound.
               rd_row = step.lo_next;
               if (member_ff && (step.lo_next != hi_ff)) begin
                  state_in = ST_CHECK;
               end else begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.position = step.lo_next;
                  rsp_in.found    = 1'b0;
                  state_in        = ST_IDLE;
               end
            end
         end
         ST_CHECK: begin
            rsp_valid_in    = 1'b1;
            rsp_in.position = lo_ff;
            rsp_in.found    = !step.key_lt_entry;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff     <= lo_in;
      count_ff  <= count_in;
      hi_ff     <= hi_in;
      key_ff    <= key_in;
      base_ff   <= base_in;
      col_ok_ff <= col_ok_in;
      upper_ff  <= upper_in;
      member_ff <= member_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   `CBS_ASSERT_HOLDS(a_count_shrinks, clock, reset, (state_ff == ST_SEARCH) |=> ((state_ff != ST_SEARCH) || (count_ff < $past(count_ff))), "search window did not shrink")
   `CBS_ASSERT_HOLDS(a_window_in_range, clock, reset, ((state_ff == ST_ISSUE) || (state_ff == ST_SEARCH)) |-> (({1'b0, lo_ff} + {1'b0, count_ff}) <= {1'b0, hi_ff}), "search window exceeds range end")
   `CBS_ASSERT_HOLDS(a_write_no_busy, clock, reset, (req_fire && (req_data.opcode == OP_WRITE)) |=> (!busy && !rsp_strobe), "write request caused work or a response")
   `CBS_ASSERT_NEVER(a_no_read_idle, clock, reset, rd_en && (state_ff == ST_IDLE), "table read issued while idle")

endmodule
